@@ hw/rtl/lzwc_pkg.sv @@
// ----------------------------------------------------------------------------
// lzwc_pkg
// Shared types and constants for the LZW byte compressor.
// ----------------------------------------------------------------------------
package lzwc_pkg;

    localparam int DICT_SIZE   = 4096;
    localparam int ROOT_COUNT  = 256;
    localparam int CELL_COUNT  = DICT_SIZE - ROOT_COUNT;
    localparam int BYTE_W      = 8;
    localparam int CODE_W      = 12;
    localparam int CODE_IW     = $clog2(DICT_SIZE);
    localparam int CNT_W       = $clog2(CELL_COUNT + 1);
    localparam int GROUP_SIZE  = 64;
    localparam int LOC_W       = $clog2(GROUP_SIZE);
    localparam int GROUP_COUNT = (CELL_COUNT + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int GRP_W       = $clog2(GROUP_COUNT);
    localparam int POS_W       = GRP_W + LOC_W;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last_in;
    } req_t;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              last_code;
    } res_t;

    typedef struct packed {
        logic [CODE_IW-1:0] prefix;
        logic [BYTE_W-1:0]  ch;
    } entry_t;

    typedef struct packed {
        logic             any;
        logic [LOC_W-1:0] idx;
    } grp_t;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CMP   = 7'b0000010,
        S_GRP   = 7'b0000100,
        S_FIN   = 7'b0001000,
        S_DEC   = 7'b0010000,
        S_EMIT1 = 7'b0100000,
        S_EMITL = 7'b1000000
    } state_t;

endpackage

@@ hw/rtl/lzw_byte_compressor.sv @@
// ----------------------------------------------------------------------------
// lzw_byte_compressor
// LZW compressor, one byte per request in, 12-bit codes out.
// ----------------------------------------------------------------------------
// Input channel byte_*: one byte per request, last_in marks end of stream.
// Output channel code_*: emitted codes, last_code on the flushed final code.
// The dictionary lives in a chain of cells; a new entry enters cell 0 and
// every older entry moves one cell down. A lookup broadcasts the pair
// (prefix, byte) to all cells, then reduces the match lines through a
// registered group encoder and a final encoder.
// Sequence: the first byte of a stream is taken in idle and becomes the prefix.
// Any other byte passes through compare, group encode, final encode and decide
// states, then one emit state per code it emits (up to 2), and back to idle.
// The three-stage lookup sets this sequence.
// A single output register parts the channels: the next byte is taken
// while the last code still waits; a stalled receiver holds the block in
// its emit states until the register frees up.
// Reset clears the prefix and empties the dictionary; a final code does
// the same, so the next byte starts an independent stream.
// ----------------------------------------------------------------------------
module lzw_byte_compressor (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           byte_valid,
    output logic           byte_ready,
    input  lzwc_pkg::req_t byte_req,
    output logic           code_valid,
    input  logic           code_ready,
    output lzwc_pkg::res_t code_req
);

    localparam int PAD = lzwc_pkg::GROUP_COUNT * lzwc_pkg::GROUP_SIZE;

    lzwc_pkg::state_t                 state_reg, state_next;
    logic [lzwc_pkg::CODE_IW-1:0]     prefix_reg, prefix_next;
    logic                             pvalid_reg, pvalid_next;
    logic [lzwc_pkg::CNT_W-1:0]       count_reg, count_next;
    logic [lzwc_pkg::BYTE_W-1:0]      byte_reg;
    logic                             last_reg;
    logic [lzwc_pkg::CODE_IW-1:0]     emit_reg, emit_next;
    logic                             out_valid_reg, out_valid_next;
    lzwc_pkg::res_t                   out_reg, out_next;
    logic                             fin_any_reg;
    logic [lzwc_pkg::POS_W-1:0]       fin_pos_reg;
    logic                             fin_any_next;
    logic [lzwc_pkg::POS_W-1:0]       fin_pos_next;

    logic                             accept;
    logic                             out_free;
    logic                             shift;
    lzwc_pkg::entry_t                 query;
    lzwc_pkg::entry_t                 new_entry;
    lzwc_pkg::entry_t                 cells [lzwc_pkg::CELL_COUNT];
    logic [PAD-1:0]                   hit_vec;
    lzwc_pkg::grp_t                   grps [lzwc_pkg::GROUP_COUNT];
    logic [lzwc_pkg::GROUP_COUNT-1:0] grp_any_vec;
    logic [lzwc_pkg::CODE_IW-1:0]     hit_code;

    assign accept   = byte_valid && byte_ready;
    assign out_free = !out_valid_reg || code_ready;

    assign query.prefix     = prefix_reg;
    assign query.ch         = byte_reg;
    assign new_entry.prefix = prefix_reg;
    assign new_entry.ch     = byte_reg;

    // dictionary chain
    for (genvar k = 0; k < lzwc_pkg::CELL_COUNT; k++)
    begin : g_cell
        lzwc_cell u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .shift  (shift),
            .active (count_reg > lzwc_pkg::CNT_W'(k)),
            .prev   ((k == 0) ? new_entry : cells[(k == 0) ? 0 : k - 1]),
            .query  (query),
            .entry  (cells[k]),
            .hit    (hit_vec[k])
        );
    end

    for (genvar k = lzwc_pkg::CELL_COUNT; k < PAD; k++)
    begin : g_pad
        assign hit_vec[k] = 1'b0;
    end

    for (genvar g = 0; g < lzwc_pkg::GROUP_COUNT; g++)
    begin : g_grp
        lzwc_group u_group (
            .clk   (clk),
            .rst_n (rst_n),
            .hits  (hit_vec[g*lzwc_pkg::GROUP_SIZE +: lzwc_pkg::GROUP_SIZE]),
            .grp   (grps[g])
        );
        assign grp_any_vec[g] = grps[g].any;
    end

    always_comb
    begin
        fin_any_next = |grp_any_vec;
        fin_pos_next = '0;
        for (int g = 0; g < lzwc_pkg::GROUP_COUNT; g++)
        begin
            if (grps[g].any)
            begin
                fin_pos_next = fin_pos_next | {lzwc_pkg::GRP_W'(g), grps[g].idx};
            end
        end
    end

    // newest entry sits in cell 0
    assign hit_code = lzwc_pkg::CODE_IW'(lzwc_pkg::ROOT_COUNT - 1)
                    + lzwc_pkg::CODE_IW'(count_reg)
                    - lzwc_pkg::CODE_IW'(fin_pos_reg);

    always_comb
    begin
        state_next     = state_reg;
        prefix_next    = prefix_reg;
        pvalid_next    = pvalid_reg;
        count_next     = count_reg;
        emit_next      = emit_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !code_ready;
        shift          = 1'b0;
        byte_ready     = 1'b0;

        case (state_reg)
            lzwc_pkg::S_IDLE:
            begin
                byte_ready = 1'b1;
                if (accept)
                begin
                    if (!pvalid_reg)
                    begin
                        prefix_next = lzwc_pkg::CODE_IW'(byte_req.data_byte);
                        pvalid_next = 1'b1;
                        state_next  = byte_req.last_in ? lzwc_pkg::S_EMITL
                                                       : lzwc_pkg::S_IDLE;
                    end
                    else
                    begin
                        state_next = lzwc_pkg::S_CMP;
                    end
                end
            end
            lzwc_pkg::S_CMP:
            begin
                state_next = lzwc_pkg::S_GRP;
            end
            lzwc_pkg::S_GRP:
            begin
                state_next = lzwc_pkg::S_FIN;
            end
            lzwc_pkg::S_FIN:
            begin
                state_next = lzwc_pkg::S_DEC;
            end
            lzwc_pkg::S_DEC:
            begin
                if (fin_any_reg)
                begin
                    prefix_next = hit_code;
                    state_next  = last_reg ? lzwc_pkg::S_EMITL : lzwc_pkg::S_IDLE;
                end
                else
                begin
                    emit_next   = prefix_reg;
                    prefix_next = lzwc_pkg::CODE_IW'(byte_reg);
                    if (count_reg < lzwc_pkg::CNT_W'(lzwc_pkg::CELL_COUNT))
                    begin
                        shift      = 1'b1;
                        count_next = count_reg + lzwc_pkg::CNT_W'(1);
                    end
                    state_next = lzwc_pkg::S_EMIT1;
                end
            end
            lzwc_pkg::S_EMIT1:
            begin
                if (out_free)
                begin
                    out_next.code      = lzwc_pkg::CODE_W'(emit_reg);
                    out_next.last_code = 1'b0;
                    out_valid_next     = 1'b1;
                    state_next         = last_reg ? lzwc_pkg::S_EMITL : lzwc_pkg::S_IDLE;
                end
            end
            lzwc_pkg::S_EMITL:
            begin
                if (out_free)
                begin
                    out_next.code      = lzwc_pkg::CODE_W'(prefix_reg);
                    out_next.last_code = 1'b1;
                    out_valid_next     = 1'b1;
                    prefix_next        = '0;
                    pvalid_next        = 1'b0;
                    count_next         = '0;
                    state_next         = lzwc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = lzwc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lzwc_pkg::S_IDLE;
            prefix_reg    <= '0;
            pvalid_reg    <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            fin_any_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prefix_reg    <= prefix_next;
            pvalid_reg    <= pvalid_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            fin_any_reg   <= fin_any_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= byte_req.data_byte;
            last_reg <= byte_req.last_in;
        end
        emit_reg    <= emit_next;
        out_reg     <= out_next;
        fin_pos_reg <= fin_pos_next;
    end

    assign code_valid = out_valid_reg;
    assign code_req   = out_reg;

    // entries are unique, so at most one group reports a match
    a_one_group_hit: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(grp_any_vec) <= 1)
        else $error("more than one dictionary group matched");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= lzwc_pkg::CNT_W'(lzwc_pkg::CELL_COUNT))
        else $error("dictionary count past capacity");

    a_empty_without_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        !pvalid_reg |-> (count_reg == '0))
        else $error("dictionary not empty at stream start");

    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lzwc_pkg::S_EMITL && out_free) |=> (!pvalid_reg && code_valid
            && code_req.last_code))
        else $error("final code did not flush the stream");

endmodule

@@ hw/rtl/lzwc_cell.sv @@
// ----------------------------------------------------------------------------
// lzwc_cell
// One dictionary cell: holds an entry, shifts it onward on insert, and
// registers a match against the broadcast query.
// ----------------------------------------------------------------------------
module lzwc_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            shift,
    input  logic            active,
    input  lzwc_pkg::entry_t prev,
    input  lzwc_pkg::entry_t query,
    output lzwc_pkg::entry_t entry,
    output logic            hit
);

    lzwc_pkg::entry_t entry_reg;
    logic             hit_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            entry_reg <= prev;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= active && (entry_reg == query);
        end
    end

    assign entry = entry_reg;
    assign hit   = hit_reg;

endmodule

@@ hw/rtl/lzwc_group.sv @@
// ----------------------------------------------------------------------------
// lzwc_group
// Encodes the match lines of one group of cells into a registered
// hit flag and local position.
// ----------------------------------------------------------------------------
module lzwc_group (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [lzwc_pkg::GROUP_SIZE-1:0]   hits,
    output lzwc_pkg::grp_t                    grp
);

    lzwc_pkg::grp_t grp_reg;
    lzwc_pkg::grp_t grp_next;

    always_comb
    begin
        grp_next.any = |hits;
        grp_next.idx = '0;
        for (int i = 0; i < lzwc_pkg::GROUP_SIZE; i++)
        begin
            if (hits[i])
            begin
                grp_next.idx = grp_next.idx | lzwc_pkg::LOC_W'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_reg <= '0;
        end
        else
        begin
            grp_reg <= grp_next;
        end
    end

    assign grp = grp_reg;

endmodule
